### rtl/xs128_pkg.sv
// ----------------------------------------------------------------------------
// xs128_pkg
// Types, constants and helper functions shared by the xorshift128 generator.
// ----------------------------------------------------------------------------
package xs128_pkg;

  // Input beat: operation kind and the seed used by a reseed.
  typedef struct packed {
    logic        kind;
    logic [31:0] seed;
  } in_t;

  // Result beat.
  typedef struct packed {
    logic [31:0] word;
    logic [63:0] fraction;
    logic        reseeded;
  } out_t;

  // Operation kinds.
  localparam logic KIND_DRAW   = 1'b0;
  localparam logic KIND_RESEED = 1'b1;

  // Seeding constants.
  localparam logic [31:0] SEED_MUL    = 32'd1812433253;
  localparam int          SEED_ROUNDS = 64;
  localparam int          ATT_W       = $clog2(SEED_ROUNDS);

  // Command group from the controller to the datapath.
  typedef struct packed {
    logic       load_zero;   // running seed <= 0
    logic       load_seed;   // running seed <= input seed
    logic       mul;         // product <= running seed * SEED_MUL
    logic       mix_wr;      // finish one seed round and write one word
    logic [1:0] word_sel;    // word written by mix_wr
    logic       step;        // one xorshift128 step
    logic       out_draw;    // load the result register with a draw result
    logic       out_reseed;  // load the result register with a reseed result
  } cmd_t;

  // Status group from the datapath to the controller.
  typedef struct packed {
    logic all_zero;
  } sts_t;

  // Per-word constant XORed into each seeded word.
  function automatic logic [31:0] seed_const(input logic [1:0] sel);
    logic [31:0] c;
    case (sel)
      2'd0:    c = 32'd123464980;
      2'd1:    c = 32'd3447902351;
      2'd2:    c = 32'd2859490775;
      default: c = 32'd47621719;
    endcase
    return c;
  endfunction

  // Second half of a seed round: add one, then the two shift-XOR stages.
  function automatic logic [31:0] seed_post(input logic [31:0] prod);
    logic [31:0] x;
    x = prod + 32'd1;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    return x;
  endfunction

endpackage

### rtl/xorshift128_generator.sv
// ----------------------------------------------------------------------------
// xorshift128_generator
// Xorshift128 pseudo-random generator with a multiply-based seeding circuit.
//
//   Channel | Ports                          | Beat
//   --------+--------------------------------+-----------------------------
//   input   | in_valid, in_ready, in_data    | kind, seed
//   result  | out_valid, out_ready, out_data | word, fraction, reseeded
//
// A draw's result is registered; draws can be accepted back to back.
// A reseed posts its result at once, then the sequencer runs each seeding
// attempt (four words at a multiply state and a mix state each, plus an
// all-zero check) before the next beat is taken.
// After reset the state is seeded from zero before in_ready rises.
// A stalled result holds its slot; a new beat is taken when it drains.
// ----------------------------------------------------------------------------
module xorshift128_generator import xs128_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  cmd_t cmd;
  sts_t sts;

  // Handshake control and seeding sequencer.
  xs128_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_data.kind),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // State words, seeding arithmetic and result register.
  xs128_dp u_dp (
    .clk      (clk),
    .seed     (in_data.seed),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

### rtl/xs128_dp.sv
// ----------------------------------------------------------------------------
// xs128_dp
// Datapath: the four state words, the seeding multiplier and the result
// register.
// ----------------------------------------------------------------------------
module xs128_dp import xs128_pkg::*; (
  input  logic        clk,
  input  logic [31:0] seed,
  input  cmd_t        cmd,
  output sts_t        sts,
  output out_t        out_data
);

  logic [31:0] a_r, b_r, c_r, d_r;
  logic [31:0] s_r, s_nxt;
  logic [31:0] prod_r;
  logic [31:0] mix;
  logic [31:0] t;
  logic [31:0] d_new;
  out_t        out_r;

  // One xorshift128 step computed from the current words.
  assign t     = a_r ^ (a_r << 11);
  assign d_new = d_r ^ (d_r >> 19) ^ t ^ (t >> 8);

  // Finished seed round.
  assign mix = seed_post(prod_r);

  // Running seed source.
  always_comb begin
    s_nxt = s_r;
    if (cmd.load_zero) begin
      s_nxt = '0;
    end else if (cmd.load_seed) begin
      s_nxt = seed;
    end else if (cmd.mix_wr) begin
      s_nxt = mix;
    end
  end

  // Seed register and the registered multiply.
  always_ff @(posedge clk) begin
    s_r <= s_nxt;
    if (cmd.mul) begin
      prod_r <= s_r * SEED_MUL;
    end
  end

  // State words: shifted by a draw, written one at a time by seeding.
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      a_r <= b_r;
      b_r <= c_r;
      c_r <= d_r;
      d_r <= d_new;
    end else if (cmd.mix_wr) begin
      case (cmd.word_sel)
        2'd0:    a_r <= seed_const(cmd.word_sel) ^ mix;
        2'd1:    b_r <= seed_const(cmd.word_sel) ^ mix;
        2'd2:    c_r <= seed_const(cmd.word_sel) ^ mix;
        default: d_r <= seed_const(cmd.word_sel) ^ mix;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.out_draw) begin
      out_r.word     <= d_new;
      out_r.fraction <= {d_new, b_r};
      out_r.reseeded <= 1'b0;
    end else if (cmd.out_reseed) begin
      out_r.word     <= '0;
      out_r.fraction <= '0;
      out_r.reseeded <= 1'b1;
    end
  end

  assign out_data     = out_r;
  assign sts.all_zero = ((a_r | b_r | c_r | d_r) == 32'd0);

endmodule

### rtl/xs128_ctrl.sv
// ----------------------------------------------------------------------------
// xs128_ctrl
// Controller: input and result handshakes and the seeding sequencer.
// ----------------------------------------------------------------------------
module xs128_ctrl import xs128_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_kind,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_MIX  = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [1:0]       idx_r, idx_nxt;
  logic [ATT_W-1:0] att_r, att_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept;

  // A new beat is taken only when idle and the result slot frees up.
  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    att_nxt   = att_r;
    cmd       = '0;
    cmd.word_sel = idx_r;
    unique case (state_r)
      S_INIT: begin
        cmd.load_zero = 1'b1;
        idx_nxt   = '0;
        att_nxt   = '0;
        state_nxt = S_MUL;
      end
      S_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_RESEED) begin
            cmd.load_seed  = 1'b1;
            cmd.out_reseed = 1'b1;
            idx_nxt   = '0;
            att_nxt   = '0;
            state_nxt = S_MUL;
          end else begin
            cmd.step     = 1'b1;
            cmd.out_draw = 1'b1;
          end
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_MIX;
      end
      S_MIX: begin
        cmd.mix_wr = 1'b1;
        idx_nxt    = idx_r + 2'd1;
        state_nxt  = (idx_r == 2'd3) ? S_CHK : S_MUL;
      end
      S_CHK: begin
        // Another attempt from the running seed if every word came out zero and attempts remain.
        if (sts.all_zero && (att_r != ATT_W'(SEED_ROUNDS - 1))) begin
          att_nxt   = att_r + ATT_W'(1);
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  // Result slot occupancy.
  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      idx_r       <= '0;
      att_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      att_r       <= att_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  // Every accepted beat leaves a result in the slot.
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted beat did not produce a result");

  // A reseed starts the seeding sequence right away.
  a_reseed_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_kind == KIND_RESEED) |=> (state_r == S_MUL))
    else $error("reseed did not start seeding");

  // Each multiply is followed by its mix cycle.
  a_mul_mix: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |=> (state_r == S_MIX))
    else $error("multiply not followed by mix");

  // The fourth word of an attempt is followed by the all-zero check.
  a_mix_chk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MIX && idx_r == 2'd3) |=> (state_r == S_CHK))
    else $error("missing check after fourth word");
`endif

endmodule

### bench/tb_xorshift128_generator.sv
// ----------------------------------------------------------------------------
// tb_xorshift128_generator
// Self-checking bench for the xorshift128 generator. A queue of draw and
// reseed beats feeds a driver that changes inputs on the falling edge. A
// monitor samples both channels on the rising edge. It predicts each accepted
// beat with a local copy of the four state words and checks every result beat
// against the oldest prediction. Idle cycles on both sides change over three
// phases, and the last phase runs with no idle cycles at all.
// ----------------------------------------------------------------------------
module tb_xorshift128_generator import xs128_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          HALF_PERIOD  = 10;
  localparam int          CYCLE_LIMIT  = 300000;
  localparam int          RANDOM_BEATS = 800;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          MAX_REPORTS  = 10;
  localparam int          SEED_TRIES   = 64;
  localparam logic [31:0] LCG_MUL      = 32'd1812433253;
  localparam logic [31:0] MIX_A        = 32'd123464980;
  localparam logic [31:0] MIX_B        = 32'd3447902351;
  localparam logic [31:0] MIX_C        = 32'd2859490775;
  localparam logic [31:0] MIX_D        = 32'd47621719;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  // Predicted generator state.
  logic [31:0] gen_a, gen_b, gen_c, gen_d;

  in_t  stim_beats[$];
  out_t pending_results[$];
  int   beats_total;
  int   beats_sent;
  int   mismatches;
  int   cycles;
  logic in_taken;

  xorshift128_generator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Free-running clock.
  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // One round of the seed scrambler: multiply-add, then two shift-XOR stages.
  function automatic logic [31:0] scramble_seed(input logic [31:0] s);
    logic [31:0] x;
    x = s * LCG_MUL + 32'd1;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    return x;
  endfunction

  // Derive all four words from a seed, retrying while they all come out zero.
  task automatic load_seed_words(input logic [31:0] seed);
    logic [31:0] s;
    s = seed;
    for (int n = 0; n < SEED_TRIES; n++) begin
      s = scramble_seed(s);
      gen_a = MIX_A ^ s;
      s = scramble_seed(s);
      gen_b = MIX_B ^ s;
      s = scramble_seed(s);
      gen_c = MIX_C ^ s;
      s = scramble_seed(s);
      gen_d = MIX_D ^ s;
      if ((gen_a | gen_b | gen_c | gen_d) != 32'd0) break;
    end
  endtask

  // Work out the result of one accepted beat and advance the predicted state.
  task automatic advance_generator(input in_t beat, output out_t res);
    logic [31:0] t;
    res = '0;
    if (beat.kind == KIND_RESEED) begin
      load_seed_words(beat.seed);
      res.reseeded = 1'b1;
    end else begin
      t     = gen_a ^ (gen_a << 11);
      gen_a = gen_b;
      gen_b = gen_c;
      gen_c = gen_d;
      gen_d = gen_d ^ (gen_d >> 19) ^ t ^ (t >> 8);
      res.word     = gen_d;
      res.fraction = {gen_d, gen_a};
    end
  endtask

  task automatic push_beat(input logic kind, input logic [31:0] seed);
    in_t b;
    b.kind = kind;
    b.seed = seed;
    stim_beats.push_back(b);
  endtask

  // Idle percentages by phase: receiver-heavy, then sender-heavy, then none.
  function automatic int sender_idle_pct();
    if (beats_sent < beats_total / 3) return 31;
    if (beats_sent < (2 * beats_total) / 3) return 60;
    return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (beats_sent < beats_total / 3) return 60;
    if (beats_sent < (2 * beats_total) / 3) return 31;
    return 0;
  endfunction

  // Driver: present the next beat once the previous one is taken.
  always @(negedge clk) begin : drive_beats
    in_t nxt;
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (stim_beats.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
          nxt = stim_beats.pop_front();
          in_data    <= nxt;
          in_valid   <= 1'b1;
          beats_sent <= beats_sent + 1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= receiver_idle_pct());
    end
  end

  // Monitor: predict accepted input beats and check accepted result beats.
  always @(posedge clk) begin : watch_beats
    out_t want;
    out_t got;
    in_taken = rst_n && in_valid && in_ready;
    if (in_taken) begin
      advance_generator(in_data, want);
      pending_results.push_back(want);
    end
    if (rst_n && out_valid && out_ready) begin
      got = out_data;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result beat: word=%h fraction=%h reseeded=%b",
                   got.word, got.fraction, got.reseeded);
      end else begin
        want = pending_results.pop_front();
        if (got.word !== want.word || got.fraction !== want.fraction ||
            got.reseeded !== want.reseeded) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"result mismatch: expected word=%h fraction=%h reseeded=%b,",
                      " got word=%h fraction=%h reseeded=%b"},
                     want.word, want.fraction, want.reseeded,
                     got.word, got.fraction, got.reseeded);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int run_len;
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_ready  = 1'b0;
    in_taken   = 1'b0;
    beats_sent = 0;
    mismatches = 0;
    cycles     = 0;

    // The block comes out of reset seeded from zero.
    load_seed_words(32'd0);

    // Directed part: draws from the reset state, seed field ignored on draws,
    // reseeds at the seed extremes and alternating bit patterns.
    push_beat(KIND_DRAW,   32'h0000_0000);
    push_beat(KIND_DRAW,   32'hFFFF_FFFF);
    push_beat(KIND_DRAW,   32'h1234_5678);
    push_beat(KIND_RESEED, 32'h0000_0000);
    push_beat(KIND_DRAW,   32'hFFFF_FFFF);
    push_beat(KIND_RESEED, 32'hFFFF_FFFF);
    push_beat(KIND_DRAW,   32'h0000_0000);
    push_beat(KIND_DRAW,   32'hFFFF_FFFF);
    push_beat(KIND_RESEED, 32'h0000_0001);
    push_beat(KIND_DRAW,   32'h0000_0000);
    push_beat(KIND_RESEED, 32'h8000_0000);
    push_beat(KIND_DRAW,   32'h8000_0000);
    push_beat(KIND_RESEED, 32'h5555_5555);
    push_beat(KIND_DRAW,   32'hAAAA_AAAA);
    push_beat(KIND_RESEED, 32'hAAAA_AAAA);
    push_beat(KIND_DRAW,   32'h5555_5555);
    push_beat(KIND_RESEED, 32'hAAAA_AAAA);
    push_beat(KIND_RESEED, 32'h5555_5555);
    push_beat(KIND_DRAW,   32'h0000_0000);
    push_beat(KIND_DRAW,   32'hFFFF_FFFF);

    // Random part: mostly runs of draws, each run opened now and then by a
    // reseed with a random seed. Draw beats carry random seed fields too.
    while (stim_beats.size() < 20 + RANDOM_BEATS) begin
      if ($urandom_range(99) < 20)
        push_beat(KIND_RESEED, $urandom());
      run_len = $urandom_range(1, 12);
      for (int n = 0; n < run_len; n++)
        push_beat(KIND_DRAW, $urandom());
    end
    beats_total = stim_beats.size();

    // Synchronous reset, released on a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for every beat to be taken and every result to come back.
    while (stim_beats.size() > 0 || in_valid || pending_results.size() > 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
rtl/xs128_pkg.sv
rtl/xs128_dp.sv
rtl/xs128_ctrl.sv
rtl/xorshift128_generator.sv
bench/tb_xorshift128_generator.sv
